### rtl/apsrd_pkg.sv
// Shared types and constants of the accelerometer peak step run detector.
// No dependencies; every other file of the block refers to it by scoped names.
package apsrd_pkg;

  localparam int ACC_W    = 16;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 14;
  localparam int MS_W     = 16;
  localparam int STEP_W   = 8;
  localparam int MAG_W    = 15;
  localparam int MAGSQ_W  = 30;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 32;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 16;

  localparam logic [MAG_W-1:0]  ONE_G    = 15'd16384;
  localparam logic [STEP_W-1:0] STEP_MAX = 8'd255;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CFG_A_W-1:0] {
    REG_PEAK_THRESHOLD  = 3'd0,
    REG_MIN_INTERVAL_MS = 3'd1,
    REG_MAX_INTERVAL_MS = 3'd2,
    REG_REQUIRED_STEPS  = 3'd3,
    REG_STOP_TIMEOUT_MS = 3'd4
  } cfg_reg_t;

  localparam logic [THR_W-1:0]  RST_PEAK_THRESHOLD  = 14'd8192;
  localparam logic [MS_W-1:0]   RST_MIN_INTERVAL_MS = 16'd250;
  localparam logic [MS_W-1:0]   RST_MAX_INTERVAL_MS = 16'd800;
  localparam logic [STEP_W-1:0] RST_REQUIRED_STEPS  = 8'd4;
  localparam logic [MS_W-1:0]   RST_STOP_TIMEOUT_MS = 16'd1000;

  // classified sample handed from front to back
  typedef struct packed {
    logic              above;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  // step and run settings used by the back end
  typedef struct packed {
    logic [MS_W-1:0]   gap_min_ms;
    logic [MS_W-1:0]   gap_max_ms;
    logic [STEP_W-1:0] run_steps;
    logic [MS_W-1:0]   stop_timeout_ms;
  } step_cfg_t;

endpackage

### rtl/apsrd_front.sv
// Front end: accepts samples, squares the axes, classifies the magnitude as outside/inside the 1g +/- threshold band.
// Uses apsrd_pkg; pushes classified items into apsrd_queue under a credit count.
module apsrd_front #(
  parameter int QUEUE_DEPTH = apsrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_x,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_y,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_z,
  input  logic [apsrd_pkg::TIME_W-1:0]     in_time_ms,
  input  logic [apsrd_pkg::THR_W-1:0]      pk_thr,
  input  logic                             pop,
  output logic                             push,
  output apsrd_pkg::item_t                 push_item
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] credit_r, credit_nxt;
  logic             s1_valid_r;
  logic [apsrd_pkg::SQ_W-1:0]    sq_x_r, sq_y_r, sq_z_r;
  logic [apsrd_pkg::TIME_W-1:0]  s1_time_r;
  logic [apsrd_pkg::MAGSQ_W-1:0] hi_sq_r, lo_sq_r;

  logic signed [31:0] prod_x, prod_y, prod_z;
  logic [apsrd_pkg::MAG_W-1:0]   hi, lo;
  logic [apsrd_pkg::MAGSQ_W-1:0] hi_sq, lo_sq;
  logic [apsrd_pkg::SUM_W-1:0]   mag_sq;
  logic                          accept;

  assign in_ready = (credit_r < CNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    credit_nxt = credit_r;
    if (accept && !pop) begin
      credit_nxt = credit_r + CNT_W'(1);
    end else if (!accept && pop) begin
      credit_nxt = credit_r - CNT_W'(1);
    end
  end

  assign prod_x = 32'(in_accel_x) * 32'(in_accel_x);
  assign prod_y = 32'(in_accel_y) * 32'(in_accel_y);
  assign prod_z = 32'(in_accel_z) * 32'(in_accel_z);

  assign hi    = apsrd_pkg::ONE_G + apsrd_pkg::MAG_W'(pk_thr);
  assign lo    = apsrd_pkg::ONE_G - apsrd_pkg::MAG_W'(pk_thr);
  assign hi_sq = apsrd_pkg::MAGSQ_W'(hi) * apsrd_pkg::MAGSQ_W'(hi);
  assign lo_sq = apsrd_pkg::MAGSQ_W'(lo) * apsrd_pkg::MAGSQ_W'(lo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      credit_r   <= credit_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    hi_sq_r <= hi_sq;
    lo_sq_r <= lo_sq;
    if (accept) begin
      sq_x_r    <= prod_x[apsrd_pkg::SQ_W-1:0];
      sq_y_r    <= prod_y[apsrd_pkg::SQ_W-1:0];
      sq_z_r    <= prod_z[apsrd_pkg::SQ_W-1:0];
      s1_time_r <= in_time_ms;
    end
  end

  assign mag_sq = apsrd_pkg::SUM_W'(sq_x_r) + apsrd_pkg::SUM_W'(sq_y_r)
                + apsrd_pkg::SUM_W'(sq_z_r);

  assign push              = s1_valid_r;
  assign push_item.above   = (mag_sq > apsrd_pkg::SUM_W'(hi_sq_r)) ||
                             (mag_sq < apsrd_pkg::SUM_W'(lo_sq_r));
  assign push_item.time_ms = s1_time_r;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CNT_W'(QUEUE_DEPTH))
    else $error("front credit count above queue depth");

  a_no_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (credit_r == '0) |-> !pop)
    else $error("pop with no transaction in flight");

endmodule

### rtl/apsrd_queue.sv
// Short queue of classified items between front and back end.
// Uses apsrd_pkg for the item type; depth comes from the top-level parameter.
module apsrd_queue #(
  parameter int QUEUE_DEPTH = apsrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  apsrd_pkg::item_t push_item,
  input  logic             pop,
  output logic             empty,
  output apsrd_pkg::item_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  apsrd_pkg::item_t entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

endmodule

### rtl/apsrd_back.sv
// Back end: step interval checks, run counter and flag, registered result stage.
// Uses apsrd_pkg; pops classified items from apsrd_queue.
module apsrd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  apsrd_pkg::step_cfg_t           cfg,
  input  logic                           empty,
  input  apsrd_pkg::item_t               head_item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_running,
  output logic                           out_peak_seen,
  output logic [apsrd_pkg::STEP_W-1:0]   out_step_count
);

  logic                          was_above_r;
  logic [apsrd_pkg::TIME_W-1:0]  last_peak_r;
  logic [apsrd_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic                          run_r, run_nxt;
  logic                          out_valid_r, out_running_r, out_peak_r;
  logic [apsrd_pkg::STEP_W-1:0]  out_steps_r;

  logic                          peak;
  logic [apsrd_pkg::TIME_W-1:0]  delta;
  logic                          in_window;
  logic [apsrd_pkg::STEP_W-1:0]  steps_win;

  assign pop   = !empty && (!out_valid_r || out_ready);
  assign peak  = head_item.above && !was_above_r;
  assign delta = head_item.time_ms - last_peak_r;

  assign in_window = (delta > apsrd_pkg::TIME_W'(cfg.gap_min_ms)) &&
                     (delta < apsrd_pkg::TIME_W'(cfg.gap_max_ms));

  always_comb begin
    steps_win = '0;
    if (in_window) begin
      steps_win = (steps_r == apsrd_pkg::STEP_MAX) ? steps_r
                                                   : steps_r + apsrd_pkg::STEP_W'(1);
    end
    steps_nxt = steps_r;
    run_nxt   = run_r;
    if (peak) begin
      steps_nxt = steps_win;
      run_nxt   = run_r || (steps_win >= cfg.run_steps);
      if (delta > apsrd_pkg::TIME_W'(cfg.stop_timeout_ms)) begin
        steps_nxt = '0;
        run_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_above_r <= 1'b0;
      last_peak_r <= '0;
      steps_r     <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        was_above_r <= head_item.above;
        steps_r     <= steps_nxt;
        run_r       <= run_nxt;
        if (peak) begin
          last_peak_r <= head_item.time_ms;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_running_r <= run_nxt;
      out_peak_r    <= peak;
      out_steps_r   <= steps_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_running    = out_running_r;
  assign out_peak_seen  = out_peak_r;
  assign out_step_count = out_steps_r;

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_steps_r == steps_r) && (out_running_r == run_r))
    else $error("result register out of step with detector state");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("queue popped while result stalled");

endmodule

### rtl/accel_peak_step_run_detector_top.sv
// Top level of the accelerometer peak step run detector: config registers and wiring.
// Uses apsrd_pkg, apsrd_front, apsrd_queue and apsrd_back.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  input   | in_valid/in_ready, accel_x/y/z, time_ms  | in
//  result  | out_valid/out_ready, running, peak_seen, | out
//          | step_count                               |
//  config  | cfg_we, cfg_addr, cfg_wdata              | in
//
// One sample per cycle sustained while out_ready holds; out_valid follows through
// registered steps: squares at the accepting edge, classify/queue write, state
// update into result register. Synchronous active-low reset; no clearing pass,
// in_ready is high once reset is released.
// A stalled result stops the back end; the front keeps accepting until the
// QUEUE_DEPTH credits of in-flight transactions are used up.
module accel_peak_step_run_detector_top #(
  parameter int QUEUE_DEPTH = apsrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_x,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_y,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_z,
  input  logic [apsrd_pkg::TIME_W-1:0]       in_time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_running,
  output logic                               out_peak_seen,
  output logic [apsrd_pkg::STEP_W-1:0]       out_step_count,
  input  logic                               cfg_we,
  input  logic [apsrd_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [apsrd_pkg::CFG_D_W-1:0]      cfg_wdata
);

  logic [apsrd_pkg::THR_W-1:0] pk_thr_r;
  apsrd_pkg::step_cfg_t        step_cfg_r;

  logic             push, pop, empty;
  apsrd_pkg::item_t push_item, head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_thr_r                   <= apsrd_pkg::RST_PEAK_THRESHOLD;
      step_cfg_r.gap_min_ms      <= apsrd_pkg::RST_MIN_INTERVAL_MS;
      step_cfg_r.gap_max_ms      <= apsrd_pkg::RST_MAX_INTERVAL_MS;
      step_cfg_r.run_steps       <= apsrd_pkg::RST_REQUIRED_STEPS;
      step_cfg_r.stop_timeout_ms <= apsrd_pkg::RST_STOP_TIMEOUT_MS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        apsrd_pkg::REG_PEAK_THRESHOLD:
          pk_thr_r <= cfg_wdata[apsrd_pkg::THR_W-1:0];
        apsrd_pkg::REG_MIN_INTERVAL_MS:
          step_cfg_r.gap_min_ms <= cfg_wdata[apsrd_pkg::MS_W-1:0];
        apsrd_pkg::REG_MAX_INTERVAL_MS:
          step_cfg_r.gap_max_ms <= cfg_wdata[apsrd_pkg::MS_W-1:0];
        apsrd_pkg::REG_REQUIRED_STEPS:
          step_cfg_r.run_steps <= cfg_wdata[apsrd_pkg::STEP_W-1:0];
        apsrd_pkg::REG_STOP_TIMEOUT_MS:
          step_cfg_r.stop_timeout_ms <= cfg_wdata[apsrd_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  apsrd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .in_time_ms     (in_time_ms),
    .pk_thr         (pk_thr_r),
    .pop            (pop),
    .push           (push),
    .push_item      (push_item)
  );

  apsrd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .empty     (empty),
    .head_item (head_item)
  );

  apsrd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (step_cfg_r),
    .empty          (empty),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_running    (out_running),
    .out_peak_seen  (out_peak_seen),
    .out_step_count (out_step_count)
  );

endmodule

### tb/apsrd_step_checker.sv
`timescale 1ns / 1ps
// Checker for the peak step run detector: watches the input, result and config ports,
// predicts each result from its own copy of the step state and compares.
// Depends on apsrd_pkg for widths and register indexes.
module apsrd_step_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_x,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_y,
  input  logic signed [apsrd_pkg::ACC_W-1:0] in_accel_z,
  input  logic [apsrd_pkg::TIME_W-1:0]       in_time_ms,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               out_running,
  input  logic                               out_peak_seen,
  input  logic [apsrd_pkg::STEP_W-1:0]       out_step_count,
  input  logic                               cfg_we,
  input  logic [apsrd_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [apsrd_pkg::CFG_D_W-1:0]      cfg_wdata,
  output int                                 err_count,
  output int                                 results_owed
);
  import apsrd_pkg::*;

  typedef struct packed {
    logic              running;
    logic              peak_seen;
    logic [STEP_W-1:0] step_count;
  } step_result_t;

  logic [THR_W-1:0]  thr_q;
  logic [MS_W-1:0]   min_q;
  logic [MS_W-1:0]   max_q;
  logic [STEP_W-1:0] req_q;
  logic [MS_W-1:0]   tout_q;

  logic              prev_above;
  logic [TIME_W-1:0] last_peak_ms;
  logic [STEP_W-1:0] step_cnt;
  logic              run_on;

  step_result_t pending_results[$];
  step_result_t want;

  task automatic report(input string field, input int exp_val, input int got_val);
    $display("%0t mismatch %s: expected %0d, got %0d", $realtime, field, exp_val, got_val);
    err_count++;
  endtask

  function automatic step_result_t predict_sample(input logic signed [ACC_W-1:0] ax,
                                                  input logic signed [ACC_W-1:0] ay,
                                                  input logic signed [ACC_W-1:0] az,
                                                  input logic [TIME_W-1:0] now_ms);
    longint       mag_sq;
    longint       hi_b;
    longint       lo_b;
    logic         above;
    logic         peak;
    logic [31:0]  gap_ms;
    step_result_t r;
    mag_sq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
           + longint'(az) * longint'(az);
    hi_b = 16384 + longint'(thr_q);
    lo_b = 16384 - longint'(thr_q);
    above = (mag_sq > hi_b * hi_b) || (mag_sq < lo_b * lo_b);
    peak = above && !prev_above;
    prev_above = above;
    if (peak) begin
      gap_ms = now_ms - last_peak_ms;
      last_peak_ms = now_ms;
      if (gap_ms > min_q && gap_ms < max_q) begin
        if (step_cnt != STEP_MAX) step_cnt = step_cnt + 1'b1;
      end else begin
        step_cnt = '0;
      end
      if (step_cnt >= req_q) run_on = 1'b1;
      if (gap_ms > tout_q) begin
        run_on = 1'b0;
        step_cnt = '0;
      end
    end
    r.running = run_on;
    r.peak_seen = peak;
    r.step_count = step_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_q = RST_PEAK_THRESHOLD;
      min_q = RST_MIN_INTERVAL_MS;
      max_q = RST_MAX_INTERVAL_MS;
      req_q = RST_REQUIRED_STEPS;
      tout_q = RST_STOP_TIMEOUT_MS;
      prev_above = 1'b0;
      last_peak_ms = '0;
      step_cnt = '0;
      run_on = 1'b0;
      pending_results.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PEAK_THRESHOLD:  thr_q = cfg_wdata[THR_W-1:0];
          REG_MIN_INTERVAL_MS: min_q = cfg_wdata;
          REG_MAX_INTERVAL_MS: max_q = cfg_wdata;
          REG_REQUIRED_STEPS:  req_q = cfg_wdata[STEP_W-1:0];
          REG_STOP_TIMEOUT_MS: tout_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_sample(in_accel_x, in_accel_y, in_accel_z,
                                                 in_time_ms));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected transaction, step_count", -1, out_step_count);
        end else begin
          want = pending_results.pop_front();
          if (out_running !== want.running)
            report("running", want.running, out_running);
          if (out_peak_seen !== want.peak_seen)
            report("peak_seen", want.peak_seen, out_peak_seen);
          if (out_step_count !== want.step_count)
            report("step_count", want.step_count, out_step_count);
        end
      end
      results_owed <= pending_results.size();
    end
  end

endmodule

### tb/accel_peak_step_run_detector_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for accel_peak_step_run_detector_top: clock, reset, config writes,
// sample stimulus and verdict. Depends on apsrd_pkg, the RTL and apsrd_step_checker.
module accel_peak_step_run_detector_top_tb;
  import apsrd_pkg::*;

  localparam logic [CFG_A_W-1:0] NO_SUCH_REG = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [ACC_W-1:0]  in_accel_x = '0;
  logic signed [ACC_W-1:0]  in_accel_y = '0;
  logic signed [ACC_W-1:0]  in_accel_z = '0;
  logic [TIME_W-1:0]        in_time_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic                     out_running;
  logic                     out_peak_seen;
  logic [STEP_W-1:0]        out_step_count;
  logic                     cfg_we = 1'b0;
  logic [CFG_A_W-1:0]       cfg_addr = '0;
  logic [CFG_D_W-1:0]       cfg_wdata = '0;
  int                       err_count;
  int                       results_owed;

  bit                in_gaps;
  bit                out_stalls;
  bit                steady;
  int                items_sent;
  logic [THR_W-1:0]  cur_thr = RST_PEAK_THRESHOLD;
  logic [MS_W-1:0]   cur_min = RST_MIN_INTERVAL_MS;
  logic [MS_W-1:0]   cur_max = RST_MAX_INTERVAL_MS;
  logic [MS_W-1:0]   cur_tout = RST_STOP_TIMEOUT_MS;
  logic [TIME_W-1:0] walk_peak_ms;

  always #2 clk = ~clk;

  accel_peak_step_run_detector_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_running(out_running), .out_peak_seen(out_peak_seen),
    .out_step_count(out_step_count),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  apsrd_step_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_running(out_running), .out_peak_seen(out_peak_seen),
    .out_step_count(out_step_count),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .err_count(err_count), .results_owed(results_owed)
  );

  task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [31:0] t);
    if (in_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_time_ms <= t;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_axis(input int mag, input logic [31:0] t);
    logic [15:0] v;
    v = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    case ($urandom_range(0, 2))
      0: send_sample(v, 0, 0, t);
      1: send_sample(0, v, 0, t);
      default: send_sample(0, 0, v, t);
    endcase
  endtask

  // magnitude inside [1g - thr, 1g + thr]
  task automatic quiet_sample(input logic [31:0] t);
    send_axis(16384 - int'(cur_thr) + $urandom_range(0, 2 * int'(cur_thr)), t);
  endtask

  task automatic peak_sample(input logic [31:0] t);
    case ($urandom_range(0, 4))
      0: send_sample(16'h8000, 16'h8000, 16'h8000, t);
      1, 2: send_axis($urandom_range(0, 16383 - int'(cur_thr)), t);
      default: send_axis($urandom_range(16385 + int'(cur_thr), 32768), t);
    endcase
  endtask

  function automatic logic [31:0] pick_gap();
    if (steady) return $urandom_range(int'(cur_min) + 1, int'(cur_max) - 1);
    case ($urandom_range(0, 11))
      0: return 32'(cur_min);
      1: return cur_min + 32'd1;
      2: return 32'(cur_max);
      3: return cur_max - 32'd1;
      4: return 32'(cur_tout);
      5: return cur_tout + 32'd1;
      6: return $urandom();
      default: begin
        if (cur_max > cur_min + 32'd1)
          return $urandom_range(int'(cur_min) + 1, int'(cur_max) - 1);
        return $urandom_range(0, 2000);
      end
    endcase
  endfunction

  task automatic step_walk();
    repeat (steady ? 1 : $urandom_range(1, 3))
      quiet_sample(walk_peak_ms + $urandom_range(0, 100));
    walk_peak_ms = walk_peak_ms + pick_gap();
    peak_sample(walk_peak_ms);
    if (!steady && $urandom_range(0, 3) == 0) peak_sample(walk_peak_ms + 32'd1);
  endtask

  task automatic run_phase(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if (!steady && $urandom_range(0, 4) == 0)
        send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    $urandom_range(0, 1) ? $urandom()
                                         : walk_peak_ms + $urandom_range(0, 1000));
      else
        step_walk();
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] thr_w, input logic [15:0] min_w,
                            input logic [15:0] max_w, input logic [15:0] req_w,
                            input logic [15:0] tout_w);
    cfg_put(REG_PEAK_THRESHOLD, thr_w);
    cfg_put(REG_MIN_INTERVAL_MS, min_w);
    cfg_put(REG_MAX_INTERVAL_MS, max_w);
    cfg_put(REG_REQUIRED_STEPS, req_w);
    cfg_put(REG_STOP_TIMEOUT_MS, tout_w);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_thr = thr_w[THR_W-1:0];
    cur_min = min_w;
    cur_max = max_w;
    cur_tout = tout_w;
  endtask

  task automatic random_config();
    logic [15:0] lo_ms;
    logic [15:0] hi_ms;
    lo_ms = 16'($urandom_range(0, 600));
    hi_ms = 16'(lo_ms + $urandom_range(0, 800));
    cfg_put(NO_SUCH_REG, 16'($urandom()));
    set_config(16'($urandom()), lo_ms, hi_ms,
               {8'($urandom()), 8'($urandom_range(0, 10))},
               $urandom_range(0, 1) ? 16'(hi_ms + $urandom_range(0, 500))
                                    : 16'($urandom_range(0, int'(hi_ms))));
    in_gaps = $urandom_range(0, 3) != 0;
    out_stalls = $urandom_range(0, 3) != 0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (out_stalls && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) if (out_stalls) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("accel_peak_step_run_detector_top_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gaps = 1'b1;
    out_stalls = 1'b1;

    // reset settings: hi bound 24576, lo bound 8192, window 250..800, timeout 1000
    send_sample(16384, 0, 0, 0);
    send_sample(24576, 0, 0, 5);
    send_sample(24577, 0, 0, 300);
    send_sample(0, 0, 0, 310);
    send_sample(0, 16'(-16384), 0, 400);
    send_sample(8192, 0, 0, 450);
    send_sample(8191, 0, 0, 550);
    send_sample(0, 16384, 0, 600);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1050);
    send_sample(0, 0, 16384, 1100);
    send_sample(32767, 32767, 32767, 1549);
    send_sample(0, 0, 16'(-16384), 1600);
    send_sample(0, 0, 16'h8000, 2348);
    send_sample(0, 0, 16384, 2400);
    send_sample(0, 0, 24577, 2647);
    send_sample(16'(-16384), 0, 0, 2700);
    send_sample(0, 0, 0, 3447);
    send_sample(16384, 0, 0, 3500);
    send_sample(0, 0, 0, 4448);
    send_sample(16384, 0, 0, 4500);
    send_sample(16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFF0);
    send_sample(0, 16384, 0, 32'hFFFF_FFF8);
    send_sample(0, 0, 0, 32'h0000_0100);
    send_sample(0, 0, 16384, 32'hFFFF_FFFF);
    walk_peak_ms = 32'h0000_0100;
    settle();

    random_config();
    run_phase(200);

    // long clean walk: count saturates, running at the top count
    settle();
    set_config(16'hC000, 0, 16'hFFFF, 16'hFF, 16'hFFFF);
    steady = 1'b1;
    run_phase(620);
    steady = 1'b0;

    // empty window, zero steps needed, zero timeout
    settle();
    set_config(16'h3FFF, 16'hFFFF, 0, 0, 0);
    run_phase(120);

    settle();
    set_config(16'($urandom()), 10, 20, 3, 25);
    run_phase(200);

    // timestamps wrap through zero
    settle();
    random_config();
    walk_peak_ms = 32'hFFFF_F000;
    run_phase(200);

    settle();
    random_config();
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    run_phase(200);

    settle();
    if (err_count == 0)
      $display("accel_peak_step_run_detector_top_tb: done, clean");
    else
      $display("accel_peak_step_run_detector_top_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/apsrd_pkg.sv
rtl/apsrd_front.sv
rtl/apsrd_queue.sv
rtl/apsrd_back.sv
rtl/accel_peak_step_run_detector_top.sv
tb/apsrd_step_checker.sv
tb/accel_peak_step_run_detector_top_tb.sv
